FILE: hw/rtl/thread_scheduler_with_mutexes_top_macros.svh
// Assertion macros for the scheduler RTL (used by tsm_core).
// Each expects clk and arst_n in the scope where it is used.
`ifndef THREAD_SCHEDULER_WITH_MUTEXES_TOP_MACROS_SVH
`define THREAD_SCHEDULER_WITH_MUTEXES_TOP_MACROS_SVH

// Same-cycle implication.
`define TSM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TSM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/tsm_pkg.sv
package tsm_pkg;

	localparam int THREAD_SLOTS = 4;
	localparam int MUTEX_COUNT  = 4;
	localparam int ID_COUNT     = THREAD_SLOTS + 1;
	// the width leaves a code past the initial context; the all-ones code is kept for "none"
	localparam int ID_W         = $clog2(THREAD_SLOTS + 2);
	localparam int IDX_W        = $clog2(ID_COUNT);
	localparam logic [ID_W-1:0] NIL_ID  = '1;
	localparam logic [ID_W-1:0] INIT_ID = ID_W'(THREAD_SLOTS);

	// fixed field widths
	localparam int OP_W     = 3;
	localparam int MUTEX_W  = 2;
	localparam int RUN_W    = 3;
	localparam int SPAWN_W  = 2;
	localparam int STATUS_W = 2;

	localparam logic [OP_W-1:0] OP_SPAWN  = 3'd0;
	localparam logic [OP_W-1:0] OP_YIELD  = 3'd1;
	localparam logic [OP_W-1:0] OP_LOCK   = 3'd2;
	localparam logic [OP_W-1:0] OP_UNLOCK = 3'd3;
	localparam logic [OP_W-1:0] OP_EXIT   = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_READY  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_INIT_EXIT = 2'd3;

	typedef struct packed {
		logic               valid;
		logic [OP_W-1:0]    op;
		logic [MUTEX_W-1:0] mutex;
	} req_t;

	typedef struct packed {
		logic                switched;
		logic [STATUS_W-1:0] status;
		logic [SPAWN_W-1:0]  spawned;
		logic [RUN_W-1:0]    running;
	} res_t;

endpackage

FILE: hw/rtl/tsm_core.sv
`include "thread_scheduler_with_mutexes_top_macros.svh"

module tsm_core (
	input  logic          clk,
	input  logic          arst_n,
	input  tsm_pkg::req_t req,
	output tsm_pkg::res_t res
);
	import tsm_pkg::*;

	logic [ID_W-1:0] running_q, run_d;
	logic [ID_W-1:0] link_q [ID_COUNT];
	logic [ID_W-1:0] link_d [ID_COUNT];
	logic [ID_W-1:0] free_head_q, free_tail_q, fh_d, ft_d;
	logic [ID_W-1:0] ready_head_q, ready_tail_q, rh_d, rt_d;
	logic [ID_W-1:0] wait_head_q [MUTEX_COUNT];
	logic [ID_W-1:0] wait_tail_q [MUTEX_COUNT];
	logic [ID_W-1:0] wh_d [MUTEX_COUNT];
	logic [ID_W-1:0] wt_d [MUTEX_COUNT];
	logic [MUTEX_COUNT-1:0] held_q, held_d;

	logic [ID_W-1:0] pop_id, pop_nxt;
	logic            mutex_ok;
	logic [STATUS_W-1:0] status;
	logic [SPAWN_W-1:0]  spawned;

	assign mutex_ok = (32'(req.mutex) < MUTEX_COUNT);

	// one queue is popped per operation: pick its head and read its link
	always_comb begin
		case (req.op)
			OP_SPAWN:  pop_id = free_head_q;
			OP_UNLOCK: pop_id = mutex_ok ? wait_head_q[req.mutex] : NIL_ID;
			default:   pop_id = ready_head_q;
		endcase
		pop_nxt = (32'(pop_id) < ID_COUNT) ? link_q[pop_id[IDX_W-1:0]] : NIL_ID;
	end

	always_comb begin
		run_d   = running_q;
		link_d  = link_q;
		fh_d    = free_head_q;
		ft_d    = free_tail_q;
		rh_d    = ready_head_q;
		rt_d    = ready_tail_q;
		wh_d    = wait_head_q;
		wt_d    = wait_tail_q;
		held_d  = held_q;
		status  = ST_OK;
		spawned = '0;
		if (req.valid) begin
			case (req.op)
				OP_SPAWN: begin
					if (free_head_q == NIL_ID) begin
						status = ST_NO_FREE;
					end else begin
						fh_d = pop_nxt;
						if (pop_nxt == NIL_ID) ft_d = NIL_ID;
						link_d[free_head_q[IDX_W-1:0]] = NIL_ID;
						link_d[running_q[IDX_W-1:0]] = NIL_ID;
						if (ready_head_q == NIL_ID) rh_d = running_q;
						else link_d[ready_tail_q[IDX_W-1:0]] = running_q;
						rt_d    = running_q;
						run_d   = free_head_q;
						spawned = SPAWN_W'(free_head_q);
					end
				end
				OP_YIELD: begin
					// empty ready queue: push then pop returns the same thread
					if (ready_head_q != NIL_ID) begin
						link_d[ready_tail_q[IDX_W-1:0]] = running_q;
						link_d[running_q[IDX_W-1:0]] = NIL_ID;
						link_d[ready_head_q[IDX_W-1:0]] = NIL_ID;
						rh_d  = (ready_head_q == ready_tail_q) ? running_q : pop_nxt;
						rt_d  = running_q;
						run_d = ready_head_q;
					end
				end
				OP_LOCK: begin
					if (mutex_ok) begin
						if (!held_q[req.mutex]) begin
							held_d[req.mutex] = 1'b1;
						end else if (ready_head_q == NIL_ID) begin
							status = ST_NO_READY;
						end else begin
							link_d[running_q[IDX_W-1:0]] = NIL_ID;
							if (wait_head_q[req.mutex] == NIL_ID) begin
								wh_d[req.mutex] = running_q;
							end else begin
								link_d[wait_tail_q[req.mutex][IDX_W-1:0]] = running_q;
							end
							wt_d[req.mutex] = running_q;
							rh_d = pop_nxt;
							if (pop_nxt == NIL_ID) rt_d = NIL_ID;
							link_d[ready_head_q[IDX_W-1:0]] = NIL_ID;
							run_d = ready_head_q;
						end
					end
				end
				OP_UNLOCK: begin
					if (mutex_ok) begin
						if (wait_head_q[req.mutex] != NIL_ID) begin
							// hand over: mutex stays held
							link_d[running_q[IDX_W-1:0]] = NIL_ID;
							if (ready_head_q == NIL_ID) rh_d = running_q;
							else link_d[ready_tail_q[IDX_W-1:0]] = running_q;
							rt_d = running_q;
							wh_d[req.mutex] = pop_nxt;
							if (pop_nxt == NIL_ID) wt_d[req.mutex] = NIL_ID;
							link_d[wait_head_q[req.mutex][IDX_W-1:0]] = NIL_ID;
							run_d = wait_head_q[req.mutex];
						end else begin
							held_d[req.mutex] = 1'b0;
						end
					end
				end
				OP_EXIT: begin
					if (running_q == INIT_ID) begin
						status = ST_INIT_EXIT;
					end else if (ready_head_q == NIL_ID) begin
						status = ST_NO_READY;
					end else begin
						link_d[running_q[IDX_W-1:0]] = NIL_ID;
						if (free_head_q == NIL_ID) fh_d = running_q;
						else link_d[free_tail_q[IDX_W-1:0]] = running_q;
						ft_d = running_q;
						rh_d = pop_nxt;
						if (pop_nxt == NIL_ID) rt_d = NIL_ID;
						link_d[ready_head_q[IDX_W-1:0]] = NIL_ID;
						run_d = ready_head_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign res.running  = RUN_W'(run_d);
	assign res.spawned  = spawned;
	assign res.status   = status;
	assign res.switched = (run_d != running_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q    <= INIT_ID;
			free_head_q  <= '0;
			free_tail_q  <= ID_W'(THREAD_SLOTS - 1);
			ready_head_q <= NIL_ID;
			ready_tail_q <= NIL_ID;
			held_q       <= '0;
			for (int i = 0; i < ID_COUNT; i++) begin
				link_q[i] <= (i + 1 < THREAD_SLOTS) ? ID_W'(i + 1) : NIL_ID;
			end
			for (int j = 0; j < MUTEX_COUNT; j++) begin
				wait_head_q[j] <= NIL_ID;
				wait_tail_q[j] <= NIL_ID;
			end
		end else if (req.valid) begin
			running_q    <= run_d;
			link_q       <= link_d;
			free_head_q  <= fh_d;
			free_tail_q  <= ft_d;
			ready_head_q <= rh_d;
			ready_tail_q <= rt_d;
			wait_head_q  <= wh_d;
			wait_tail_q  <= wt_d;
			held_q       <= held_d;
		end
	end

	`TSM_ASSERT_IMP(a_running_in_range, 1'b1, running_q <= INIT_ID, "running id out of range")
	`TSM_ASSERT_IMP(a_ready_ends_agree, 1'b1, (ready_head_q == NIL_ID) == (ready_tail_q == NIL_ID), "ready queue head and tail disagree")
	`TSM_ASSERT_IMP(a_free_ends_agree, 1'b1, (free_head_q == NIL_ID) == (free_tail_q == NIL_ID), "free pool head and tail disagree")
	`TSM_ASSERT_NEXT(a_error_no_change, req.valid && status != ST_OK, $stable(running_q) && $stable(free_head_q) && $stable(ready_head_q), "failed operation changed state")
	`TSM_ASSERT_IMP(a_spawn_only, req.valid && spawned != '0, req.op == OP_SPAWN && status == ST_OK, "spawned slot reported outside spawn")

endmodule

FILE: hw/rtl/thread_scheduler_with_mutexes_top.sv
// Channel  Direction  tdata (low bit up)                                   tuser/tlast
// s_*      in         operation[2:0] mutex_index[4:3] zero[7:5]            none
// m_*      out        running_thread[2:0] spawned_thread[4:3] status[6:5]  none
//                     switched[7]
//
// An operation is registered on transfer and resolved into the result register when the
// output can advance; a new operation is taken every cycle while the output is not stalled.
// The single-pass queue update (one pop read of the shared link table) sets this rate.
// arst_n clears the queues to the reset layout: all slots free, initial context running.
// A stalled result holds in the output register; one operation more waits in the
// input register, then s_tready drops.
module thread_scheduler_with_mutexes_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // operation[2:0], mutex_index[4:3], zero
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // running_thread[2:0], spawned_thread[4:3], status[6:5], switched[7]
);
	import tsm_pkg::*;

	logic               req_valid_s1;
	logic [OP_W-1:0]    op_s1;
	logic [MUTEX_W-1:0] mutex_s1;
	logic               res_valid_s2;
	res_t               res_s2;
	res_t               res;
	req_t               req;
	logic               advance;

	assign advance  = !res_valid_s2 || m_tready;
	assign s_tready = !req_valid_s1 || advance;

	assign req.valid = req_valid_s1 && advance;
	assign req.op    = op_s1;
	assign req.mutex = mutex_s1;

	tsm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
			res_valid_s2 <= 1'b0;
		end else begin
			if (s_tready) req_valid_s1 <= s_tvalid;
			if (advance) res_valid_s2 <= req_valid_s1;
		end
	end

	// payload: load on transfer, hold otherwise
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1    <= s_tdata[OP_W-1:0];
			mutex_s1 <= s_tdata[OP_W+MUTEX_W-1:OP_W];
		end
		if (req.valid) res_s2 <= res;
	end

	assign m_tvalid = res_valid_s2;
	assign m_tdata  = {res_s2.switched, res_s2.status, res_s2.spawned, res_s2.running};

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import tsm_pkg::*;

	localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
	localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

	// queue ids in the scheduler model: free pool, ready FIFO, then one wait FIFO per mutex
	localparam int FREE_Q      = 0;
	localparam int READY_Q     = 1;
	localparam int WAIT_Q0     = 2;
	localparam int QUEUE_COUNT = WAIT_Q0 + MUTEX_COUNT;

	localparam int RANDOM_OPS  = 1600;
	localparam int CALM_AFTER  = 1400;
	localparam int HOLD_AT     = 400;
	localparam int DRAIN_AT    = 800;
	localparam int HOLD_CYCLES = 120;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [MUTEX_W-1:0] mx;
		logic               known;
		res_t               res;   // switched, status, spawned, running
	} script_row_t;

	localparam int SCRIPT_LEN = 25;
	localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
		'{OP_EXIT,   2'd0, 1'b1, '{1'b0, ST_INIT_EXIT, 2'd0, 3'd4}},
		'{OP_YIELD,  2'd1, 1'b1, '{1'b0, ST_OK,        2'd0, 3'd4}},
		'{OP_LOCK,   2'd0, 1'b1, '{1'b0, ST_OK,        2'd0, 3'd4}},
		'{OP_LOCK,   2'd0, 1'b1, '{1'b0, ST_NO_READY,  2'd0, 3'd4}},
		'{OP_UNLOCK, 2'd3, 1'b1, '{1'b0, ST_OK,        2'd0, 3'd4}},
		'{OP_SPAWN,  2'd2, 1'b0, '0},
		'{OP_SPAWN,  2'd0, 1'b0, '0},
		'{OP_SPAWN,  2'd1, 1'b0, '0},
		'{OP_SPAWN,  2'd3, 1'b1, '{1'b1, ST_OK,        2'd3, 3'd3}},
		'{OP_SPAWN,  2'd0, 1'b1, '{1'b0, ST_NO_FREE,   2'd0, 3'd3}},
		'{OP_LOCK,   2'd0, 1'b0, '0},
		'{OP_LOCK,   2'd3, 1'b0, '0},
		'{OP_LOCK,   2'd3, 1'b0, '0},
		'{OP_YIELD,  2'd2, 1'b0, '0},
		'{OP_UNLOCK, 2'd0, 1'b0, '0},
		'{OP_UNLOCK, 2'd0, 1'b0, '0},
		'{OP_EXIT,   2'd1, 1'b0, '0},
		'{OP_EXIT,   2'd2, 1'b0, '0},
		'{OP_EXIT,   2'd3, 1'b0, '0},
		'{OP_EXIT,   2'd0, 1'b1, '{1'b0, ST_NO_READY,  2'd0, 3'd1}},
		'{OP_UNLOCK, 2'd3, 1'b0, '0},
		'{OP_RSVD5,  2'd3, 1'b1, '{1'b0, ST_OK,        2'd0, 3'd4}},
		'{OP_RSVD7,  2'd2, 1'b1, '{1'b0, ST_OK,        2'd0, 3'd4}},
		'{OP_RSVD6,  2'd1, 1'b1, '{1'b0, ST_OK,        2'd0, 3'd4}},
		'{OP_EXIT,   2'd3, 1'b1, '{1'b0, ST_INIT_EXIT, 2'd0, 3'd4}}
	};

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;   // operation[2:0], mutex_index[4:3], zero[7:5]
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;   // running_thread[2:0], spawned_thread[4:3], status[6:5], switched[7]

	thread_scheduler_with_mutexes_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// scheduler state as the testbench sees it
	logic [ID_W-1:0] cur_thread;
	logic [ID_W-1:0] link_nxt [ID_COUNT];
	logic [ID_W-1:0] q_head [QUEUE_COUNT];
	logic [ID_W-1:0] q_tail [QUEUE_COUNT];
	logic            held [MUTEX_COUNT];

	res_t sched_results_q [$];
	res_t mon_got;
	res_t mon_want;
	int   mismatches;
	int   results_checked;
	int   op_count [8];
	int   sched_ops;
	bit   hold_req;
	bit   calm;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void reset_schedule();
		cur_thread = INIT_ID;
		for (int i = 0; i < ID_COUNT; i++)
			link_nxt[i] = NIL_ID;
		for (int i = 0; i + 1 < THREAD_SLOTS; i++)
			link_nxt[i] = ID_W'(i + 1);
		for (int q = 0; q < QUEUE_COUNT; q++) begin
			q_head[q] = NIL_ID;
			q_tail[q] = NIL_ID;
		end
		q_head[FREE_Q] = '0;
		q_tail[FREE_Q] = ID_W'(THREAD_SLOTS - 1);
		for (int m = 0; m < MUTEX_COUNT; m++)
			held[m] = 1'b0;
	endfunction

	function automatic void enqueue_id(int q, logic [ID_W-1:0] id);
		link_nxt[id] = NIL_ID;
		if (q_head[q] == NIL_ID)
			q_head[q] = id;
		else
			link_nxt[q_tail[q]] = id;
		q_tail[q] = id;
	endfunction

	function automatic logic [ID_W-1:0] dequeue_id(int q);
		logic [ID_W-1:0] id;
		id = q_head[q];
		q_head[q] = link_nxt[id];
		if (q_head[q] == NIL_ID)
			q_tail[q] = NIL_ID;
		link_nxt[id] = NIL_ID;
		return id;
	endfunction

	function automatic res_t schedule_op(logic [OP_W-1:0] op, logic [MUTEX_W-1:0] mx);
		res_t            r;
		logic [ID_W-1:0] prev;
		logic [ID_W-1:0] slot;
		prev = cur_thread;
		r = '0;
		r.status = ST_OK;
		case (op)
			OP_SPAWN: begin
				if (q_head[FREE_Q] == NIL_ID) begin
					r.status = ST_NO_FREE;
				end else begin
					slot = dequeue_id(FREE_Q);
					enqueue_id(READY_Q, cur_thread);
					cur_thread = slot;
					r.spawned = slot[SPAWN_W-1:0];
				end
			end
			OP_YIELD: begin
				// an empty ready FIFO hands the same thread straight back
				enqueue_id(READY_Q, cur_thread);
				cur_thread = dequeue_id(READY_Q);
			end
			OP_LOCK: begin
				if (!held[mx]) begin
					held[mx] = 1'b1;
				end else if (q_head[READY_Q] == NIL_ID) begin
					r.status = ST_NO_READY;
				end else begin
					enqueue_id(WAIT_Q0 + int'(mx), cur_thread);
					cur_thread = dequeue_id(READY_Q);
				end
			end
			OP_UNLOCK: begin
				// hand the mutex to the first waiter; it stays held
				if (q_head[WAIT_Q0 + int'(mx)] != NIL_ID) begin
					enqueue_id(READY_Q, cur_thread);
					cur_thread = dequeue_id(WAIT_Q0 + int'(mx));
				end else begin
					held[mx] = 1'b0;
				end
			end
			OP_EXIT: begin
				if (cur_thread == INIT_ID) begin
					r.status = ST_INIT_EXIT;
				end else if (q_head[READY_Q] == NIL_ID) begin
					r.status = ST_NO_READY;
				end else begin
					enqueue_id(FREE_Q, cur_thread);
					cur_thread = dequeue_id(READY_Q);
				end
			end
			default: ;
		endcase
		r.running = cur_thread[RUN_W-1:0];
		r.switched = (cur_thread != prev);
		return r;
	endfunction

	task automatic issue_op(input logic [OP_W-1:0] op, input logic [MUTEX_W-1:0] mx,
			input logic known, input res_t typed);
		res_t predicted;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, mx, op};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = schedule_op(op, mx);
		sched_results_q.push_back(known ? typed : predicted);
		op_count[op]++;
	endtask

	task automatic pause_sender(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
	endtask

	initial begin
		script_row_t        row;
		logic [OP_W-1:0]    op;
		logic [MUTEX_W-1:0] mx;
		int                 pick;
		bit                 did_hold;
		bit                 did_drain;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		hold_req = 1'b0;
		calm = 1'b0;
		did_hold = 1'b0;
		did_drain = 1'b0;
		sched_ops = 0;
		reset_schedule();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		foreach (SCRIPT[i]) begin
			row = SCRIPT[i];
			issue_op(row.op, row.mx, row.known, row.res);
		end

		while (sched_ops < RANDOM_OPS) begin
			calm = (sched_ops >= CALM_AFTER);
			if (!did_hold && sched_ops >= HOLD_AT) begin
				// stall the output while the sender keeps offering operations
				did_hold = 1'b1;
				hold_req = 1'b1;
			end
			if (!did_drain && sched_ops >= DRAIN_AT) begin
				did_drain = 1'b1;
				pause_sender(1);
				while (sched_results_q.size() != 0)
					@(posedge clk);
			end
			if (!calm && $urandom_range(0, 5) == 0)
				pause_sender($urandom_range(1, 17));
			pick = $urandom_range(0, 99);
			if (pick < 4)
				op = 3'($urandom_range(OP_RSVD5, OP_RSVD7));
			else if (pick < 24)
				op = OP_SPAWN;
			else if (pick < 44)
				op = OP_YIELD;
			else if (pick < 64)
				op = OP_LOCK;
			else if (pick < 82)
				op = OP_UNLOCK;
			else
				op = OP_EXIT;
			mx = 2'($urandom_range(0, MUTEX_COUNT - 1));
			issue_op(op, mx, 1'b0, '0);
			if (op <= OP_EXIT)
				sched_ops++;
		end

		pause_sender(1);
		while (sched_results_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Checked %0d results: spawn %0d, yield %0d, lock %0d, unlock %0d, exit %0d,",
			results_checked, op_count[OP_SPAWN], op_count[OP_YIELD], op_count[OP_LOCK],
			op_count[OP_UNLOCK], op_count[OP_EXIT]);
		$display("  reserved opcodes %0d, one long output stall and one full drain.",
			op_count[OP_RSVD5] + op_count[OP_RSVD6] + op_count[OP_RSVD7]);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int cycles;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				repeat (HOLD_CYCLES) begin
					@(negedge clk);
					m_tready <= 1'b0;
				end
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				cycles = $urandom_range(1, 17);
				repeat (cycles) begin
					@(negedge clk);
					m_tready <= 1'b0;
				end
			end else begin
				cycles = $urandom_range(1, 20);
				repeat (cycles) begin
					@(negedge clk);
					m_tready <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			mon_got = res_t'(m_tdata);
			if (sched_results_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result running=%0d spawned=%0d status=%0d switched=%0d",
						$realtime, mon_got.running, mon_got.spawned, mon_got.status,
						mon_got.switched);
			end else begin
				mon_want = sched_results_q.pop_front();
				results_checked++;
				if (mon_got.running !== mon_want.running || mon_got.spawned !== mon_want.spawned ||
						mon_got.status !== mon_want.status ||
						mon_got.switched !== mon_want.switched) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result %0d expected run=%0d spawn=%0d st=%0d sw=%0d, got run=%0d spawn=%0d st=%0d sw=%0d",
							$realtime, results_checked, mon_want.running, mon_want.spawned,
							mon_want.status, mon_want.switched, mon_got.running,
							mon_got.spawned, mon_got.status, mon_got.switched);
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/tsm_pkg.sv
hw/rtl/tsm_core.sv
hw/rtl/thread_scheduler_with_mutexes_top.sv
test/tb_top.sv
